// ===== sv/srcc_pkg.sv =====
// Shared types, constants and the CRC-32 byte update for the stored record checker.
package srcc_pkg;

    localparam int LEN_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH   = 4;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    localparam logic [CFG_INDEX_W-1:0] REG_MODE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAGIC   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VERSION = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH  = 2'd3;

    localparam logic MODE_VERIFY   = 1'b0;
    localparam logic MODE_GENERATE = 1'b1;

    localparam logic CMD_HEADER = 1'b0;
    localparam logic CMD_DATA   = 1'b1;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_HEADER = 3'd2;
    localparam logic [2:0] ST_CRC    = 3'd3;
    localparam logic [2:0] ST_LENGTH = 3'd4;

    typedef struct packed {
        logic        cmd;
        logic [31:0] stored_magic;
        logic [31:0] stored_version;
        logic [31:0] stored_checksum;
        logic [15:0] stored_length;
        logic [7:0]  data_byte;
        logic        last;
        logic        read_fault;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] computed_crc;
    } out_item_t;

    // classified work handed from the front to the back
    typedef struct packed {
        logic        is_hdr;
        logic        emit;
        logic [2:0]  status;
        logic [31:0] checksum;
        logic [7:0]  data_byte;
        logic        last;
        logic        fault;
    } op_t;

    localparam int OP_W = $bits(op_t);

    function automatic logic [31:0] crc_feed(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

// ===== sv/stored_record_crc_checker.sv =====
// Top level: configuration registers, front part, work queue and back part.
// The item that closes a result passes the work queue, then the result register.
// One item per cycle unless the queue is full; the back part updates the CRC per byte.
// The work queue and the result register let either side stall alone.
// Reset (rst_n low, asynchronous) clears the registers, the queue and the CRC to all ones.
module stored_record_crc_checker
    import srcc_pkg::*;
#(
    parameter int LEN_WIDTH = LEN_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  in_item_t               item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output out_item_t              result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic                  mode_reg;
    logic [31:0]           magic_reg;
    logic [31:0]           version_reg;
    logic [LEN_WIDTH-1:0]  elen_reg;
    logic [LEN_WIDTH+15:0] elen_ext;
    logic                  restart;
    logic                  q_full, q_push, q_valid, q_pop;
    op_t                   push_op, head_op;

    assign elen_ext = {{LEN_WIDTH{1'b0}}, cfg_data[15:0]};
    assign restart  = cfg_we && (cfg_index == REG_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_VERIFY;
            magic_reg   <= '0;
            version_reg <= '0;
            elen_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:    mode_reg    <= cfg_data[0];
                REG_MAGIC:   magic_reg   <= cfg_data[31:0];
                REG_VERSION: version_reg <= cfg_data[31:0];
                REG_LENGTH:  elen_reg    <= elen_ext[LEN_WIDTH-1:0];
                default:     mode_reg    <= mode_reg;
            endcase
        end
    end

    srcc_front #(
        .LEN_WIDTH(LEN_WIDTH)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .item             (item),
        .mode             (mode_reg),
        .expected_magic   (magic_reg),
        .expected_version (version_reg),
        .expected_length  (elen_reg),
        .restart          (restart),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_op             (push_op)
    );

    srcc_queue #(
        .WIDTH(OP_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (push_op),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (head_op)
    );

    srcc_back #(
        .LEN_WIDTH(LEN_WIDTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .mode            (mode_reg),
        .expected_length (elen_reg),
        .restart         (restart),
        .q_valid         (q_valid),
        .q_op            (head_op),
        .q_pop           (q_pop),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result          (result)
    );

endmodule

// ===== sv/srcc_queue.sv =====
// Small register FIFO between the front and back parts.
module srcc_queue
    import srcc_pkg::*;
#(
    parameter int WIDTH = OP_W,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/srcc_front.sv =====
// Front part: accepts items, checks headers, tracks record phase, issues work.
module srcc_front
    import srcc_pkg::*;
#(
    parameter int LEN_WIDTH = LEN_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  in_item_t             item,
    input  logic                 mode,
    input  logic [31:0]          expected_magic,
    input  logic [31:0]          expected_version,
    input  logic [LEN_WIDTH-1:0] expected_length,
    input  logic                 restart,
    input  logic                 q_full,
    output logic                 q_push,
    output op_t                  q_op
);

    typedef enum logic [1:0] {
        PH_AWAIT,
        PH_COLLECT,
        PH_IGNORE
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic                  accept;
    logic                  mismatch;
    logic [LEN_WIDTH+15:0] len_ext;
    logic [LEN_WIDTH-1:0]  s_len;

    assign item_ready = !q_full;
    assign accept     = item_valid && item_ready;
    assign len_ext    = {{LEN_WIDTH{1'b0}}, item.stored_length};
    assign s_len      = len_ext[LEN_WIDTH-1:0];
    assign mismatch   = (item.stored_magic != expected_magic)
                     || (item.stored_version != expected_version)
                     || (s_len != expected_length);

    always_comb
    begin
        phase_next       = phase_reg;
        q_push           = 1'b0;
        q_op.is_hdr      = (item.cmd == CMD_HEADER);
        q_op.emit        = 1'b0;
        q_op.status      = ST_OK;
        q_op.checksum    = item.stored_checksum;
        q_op.data_byte   = item.data_byte;
        q_op.last        = item.last;
        q_op.fault       = item.read_fault;
        if (item.cmd == CMD_HEADER)
        begin
            if (mode == MODE_VERIFY)
            begin
                q_push = accept;
                if (item.read_fault)
                begin
                    q_op.emit   = 1'b1;
                    q_op.status = ST_READ;
                    phase_next  = PH_IGNORE;
                end
                else if (mismatch)
                begin
                    q_op.emit   = 1'b1;
                    q_op.status = ST_HEADER;
                    phase_next  = PH_IGNORE;
                end
                else if (expected_length == '0)
                begin
                    q_op.emit   = 1'b1;
                    q_op.status = (item.stored_checksum == '0) ? ST_OK : ST_CRC;
                    phase_next  = PH_AWAIT;
                end
                else
                begin
                    phase_next = PH_COLLECT;
                end
            end
        end
        else if (mode == MODE_GENERATE || phase_reg == PH_COLLECT)
        begin
            q_push = accept;
            if (item.last)
            begin
                phase_next = PH_AWAIT;
            end
        end
        if (!accept)
        begin
            phase_next = phase_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_AWAIT;
        end
        else if (restart)
        begin
            phase_reg <= PH_AWAIT;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== sv/srcc_back.sv =====
// Back part: CRC-32 update, byte count, status decision and result register.
module srcc_back
    import srcc_pkg::*;
#(
    parameter int LEN_WIDTH = LEN_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 mode,
    input  logic [LEN_WIDTH-1:0] expected_length,
    input  logic                 restart,
    input  logic                 q_valid,
    input  op_t                  q_op,
    output logic                 q_pop,
    output logic                 result_valid,
    input  logic                 result_ready,
    output out_item_t            result
);

    logic [31:0]          crc_reg, crc_next;
    logic [LEN_WIDTH-1:0] count_reg, count_next;
    logic                 fault_reg, fault_next;
    logic [31:0]          chk_reg, chk_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_reg, out_next;
    logic                 can_take, makes_result;
    logic [31:0]          crc_upd, crc_fin;
    logic                 fault_all;
    logic [LEN_WIDTH:0]   total;

    assign can_take     = !out_valid_reg || result_ready;
    assign makes_result = q_op.is_hdr ? q_op.emit : q_op.last;
    assign q_pop        = q_valid && (can_take || !makes_result);
    assign crc_upd      = crc_feed(crc_reg, q_op.data_byte);
    assign crc_fin      = ~crc_upd;
    assign fault_all    = fault_reg || q_op.fault;
    assign total        = {1'b0, count_reg} + 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        crc_next       = crc_reg;
        count_next     = count_reg;
        fault_next     = fault_reg;
        chk_next       = chk_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        if (q_pop)
        begin
            if (q_op.is_hdr)
            begin
                crc_next   = CRC_INIT;
                count_next = '0;
                fault_next = 1'b0;
                chk_next   = q_op.checksum;
                if (q_op.emit)
                begin
                    out_valid_next        = 1'b1;
                    out_next.status       = q_op.status;
                    out_next.computed_crc = '0;
                end
            end
            else if (!q_op.last)
            begin
                crc_next   = crc_upd;
                fault_next = fault_all;
                if (count_reg != '1)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                crc_next              = CRC_INIT;
                count_next            = '0;
                fault_next            = 1'b0;
                out_valid_next        = 1'b1;
                out_next.computed_crc = crc_fin;
                if (fault_all)
                begin
                    out_next.status = ST_READ;
                end
                else if (mode == MODE_GENERATE)
                begin
                    out_next.status = ST_OK;
                end
                else if (total != {1'b0, expected_length})
                begin
                    out_next.status = ST_LENGTH;
                end
                else if (crc_fin != chk_reg)
                begin
                    out_next.status = ST_CRC;
                end
                else
                begin
                    out_next.status = ST_OK;
                end
            end
        end
        if (restart)
        begin
            crc_next   = CRC_INIT;
            count_next = '0;
            fault_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= CRC_INIT;
            count_reg     <= '0;
            fault_reg     <= 1'b0;
            chk_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            count_reg     <= count_next;
            fault_reg     <= fault_next;
            chk_reg       <= chk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

// ===== test/stored_record_crc_checker_tb.sv =====
// Testbench for stored_record_crc_checker: directed table, then random records checked against a CRC-32 record tracker.
`timescale 1ns / 100ps

module stored_record_crc_checker_tb;
    import srcc_pkg::*;

    localparam int LIMIT         = 1000000;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 120;
    localparam bit CALC          = 1'b0;
    localparam bit KNOWN         = 1'b1;

    typedef enum logic [1:0] {AWAIT_HDR, COLLECTING, IGNORING} rec_phase_e;
    typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_WRITE} row_kind_e;

    typedef struct {
        row_kind_e               kind;
        in_item_t                stim;
        logic                    has_res;
        out_item_t               res;
        logic [CFG_INDEX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0]   val;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   item_valid;
    logic                   item_ready;
    in_item_t               item_in;
    logic                   result_valid;
    logic                   result_ready;
    out_item_t              result_out;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // record tracker state
    logic        cur_mode;
    logic [31:0] want_magic;
    logic [31:0] want_version;
    logic [15:0] want_len;
    logic [31:0] crc_acc;
    logic [15:0] byte_cnt;
    logic [31:0] hdr_sum;
    rec_phase_e  rec_phase;
    logic        fault_flag;

    out_item_t   record_reports[$];
    plan_row_t   plan[$];
    int          mismatches = 0;
    int          effective_items = 0;
    int          cycles = 0;
    bit          src_idle = 1'b1;
    bit          sink_idle = 1'b1;
    bit          hold_req = 1'b0;

    stored_record_crc_checker DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item_in),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_out),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        logic        fb;
        r = c;
        for (int i = 0; i < 8; i++)
        begin
            fb = r[0] ^ b[i];
            r = r >> 1;
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    function automatic void restart_record();
        crc_acc = CRC_INIT;
        byte_cnt = '0;
        fault_flag = 1'b0;
    endfunction

    // advances the tracker by one item; returns 1 unless the item is ignored
    function automatic bit track_record(input in_item_t it, output out_item_t res,
                                        output bit has_res);
        logic [31:0] fin;
        logic [16:0] total;
        has_res = 1'b0;
        res = '0;
        if (it.cmd == CMD_HEADER)
        begin
            if (cur_mode == MODE_GENERATE)
                return 1'b0;
            restart_record();
            has_res = 1'b1;
            if (it.read_fault)
            begin
                rec_phase = IGNORING;
                res.status = ST_READ;
            end
            else if (it.stored_magic != want_magic || it.stored_version != want_version
                     || it.stored_length != want_len)
            begin
                rec_phase = IGNORING;
                res.status = ST_HEADER;
            end
            else
            begin
                hdr_sum = it.stored_checksum;
                if (want_len == '0)
                begin
                    rec_phase = AWAIT_HDR;
                    res.status = (it.stored_checksum == '0) ? ST_OK : ST_CRC;
                end
                else
                begin
                    rec_phase = COLLECTING;
                    has_res = 1'b0;
                end
            end
            return 1'b1;
        end
        if (cur_mode == MODE_VERIFY && rec_phase != COLLECTING)
            return 1'b0;
        crc_acc = crc32_step(crc_acc, it.data_byte);
        if (it.read_fault)
            fault_flag = 1'b1;
        if (!it.last)
        begin
            if (byte_cnt != 16'hFFFF)
                byte_cnt = byte_cnt + 16'd1;
            return 1'b1;
        end
        fin = ~crc_acc;
        total = {1'b0, byte_cnt} + 17'd1;
        has_res = 1'b1;
        res.computed_crc = fin;
        if (fault_flag)
            res.status = ST_READ;
        else if (cur_mode == MODE_GENERATE)
            res.status = ST_OK;
        else if (total != {1'b0, want_len})
            res.status = ST_LENGTH;
        else if (fin != hdr_sum)
            res.status = ST_CRC;
        else
            res.status = ST_OK;
        rec_phase = AWAIT_HDR;
        restart_record();
        return 1'b1;
    endfunction

    function automatic in_item_t hdr(input logic [31:0] m, input logic [31:0] v,
                                     input logic [31:0] s, input logic [15:0] l,
                                     input logic f);
        in_item_t it;
        it.cmd = CMD_HEADER;
        it.stored_magic = m;
        it.stored_version = v;
        it.stored_checksum = s;
        it.stored_length = l;
        it.data_byte = 8'($urandom);
        it.last = 1'($urandom);
        it.read_fault = f;
        return it;
    endfunction

    function automatic in_item_t dat(input logic [7:0] b, input logic l, input logic f);
        in_item_t it;
        it.cmd = CMD_DATA;
        it.stored_magic = $urandom;
        it.stored_version = $urandom;
        it.stored_checksum = $urandom;
        it.stored_length = 16'($urandom);
        it.data_byte = b;
        it.last = l;
        it.read_fault = f;
        return it;
    endfunction

    function automatic void add_stim(input in_item_t stim, input bit typed, input logic has_res,
                                     input logic [2:0] st, input logic [31:0] crc);
        plan_row_t r;
        r.kind = typed ? ROW_TYPED : ROW_ITEM;
        r.stim = stim;
        r.has_res = has_res;
        r.res.status = st;
        r.res.computed_crc = crc;
        r.idx = REG_MODE;
        r.val = '0;
        plan.push_back(r);
    endfunction

    function automatic void add_write(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        plan_row_t r;
        r.kind = ROW_WRITE;
        r.stim = '0;
        r.has_res = 1'b0;
        r.res = '0;
        r.idx = idx;
        r.val = val;
        plan.push_back(r);
    endfunction

    function automatic void report_mismatch(input string what, input logic [31:0] want,
                                            input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %0s: expected %h got %h at %0t", what, want, got, $time);
    endfunction

    always @(negedge clk)
    begin
        out_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (record_reports.size() == 0)
                report_mismatch("unexpected item, crc", 32'h0, result_out.computed_crc);
            else
            begin
                want = record_reports.pop_front();
                if (result_out.status !== want.status)
                    report_mismatch("status", {29'd0, want.status}, {29'd0, result_out.status});
                if (result_out.computed_crc !== want.computed_crc)
                    report_mismatch("computed_crc", want.computed_crc, result_out.computed_crc);
            end
        end
    end

    // result side: random stalls, plus one long hold on request
    initial
    begin
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_ready <= 1'b1;
                hold_req <= 1'b0;
            end
            else if (sink_idle && $urandom_range(0, 5) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                result_ready <= 1'b1;
            end
            else
                result_ready <= 1'b1;
        end
    end

    task automatic send_item(input in_item_t it, input bit use_typed, input logic typed_has,
                             input out_item_t typed_res);
        out_item_t res;
        bit        has_res;
        if (src_idle && $urandom_range(0, 7) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item_in <= it;
        forever
        begin
            @(negedge clk);
            if (item_ready)
                break;
        end
        @(posedge clk);
        if (track_record(it, res, has_res))
            effective_items++;
        if (use_typed)
        begin
            if (typed_has)
                record_reports.push_back(typed_res);
        end
        else if (has_res)
            record_reports.push_back(res);
    endtask

    task automatic send(input in_item_t it);
        send_item(it, 1'b0, 1'b0, '0);
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        while (record_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MODE:
            begin
                cur_mode = val[0];
                rec_phase = AWAIT_HDR;
                restart_record();
            end
            REG_MAGIC:   want_magic = val;
            REG_VERSION: want_version = val;
            REG_LENGTH:  want_len = val[15:0];
            default:     ;
        endcase
    endtask

    task automatic configure(input logic mode_v, input logic [31:0] m, input logic [31:0] v,
                             input logic [15:0] l);
        logic [31:0] junk;
        junk = $urandom;
        settle();
        write_reg(REG_MODE, {junk[31:1], mode_v});
        write_reg(REG_MAGIC, m);
        write_reg(REG_VERSION, v);
        write_reg(REG_LENGTH, {junk[31:16], l});
    endtask

    // header (verify mode; at times a random one in generate mode) then n bytes, of which only the first 'sent' go out
    task automatic send_record(input int n, input int sent, input bit good_sum,
                               input int fault_odds);
        logic [7:0]  body[];
        logic [31:0] sum;
        body = new[n];
        sum = CRC_INIT;
        for (int k = 0; k < n; k++)
        begin
            body[k] = 8'($urandom);
            sum = crc32_step(sum, body[k]);
        end
        sum = good_sum ? ~sum : $urandom;
        if (cur_mode == MODE_VERIFY)
            send(hdr(want_magic, want_version, sum, want_len, 1'b0));
        else if ($urandom_range(0, 4) == 0)
            send(hdr($urandom, $urandom, $urandom, 16'($urandom), 1'($urandom)));
        for (int k = 0; k < sent; k++)
            send(dat(body[k], k == n - 1,
                     fault_odds != 0 && $urandom_range(1, fault_odds) == 1));
    endtask

    task automatic run_records(input int target);
        int       stop;
        int       pick;
        int       n;
        in_item_t it;
        stop = effective_items + target;
        while (effective_items < stop)
        begin
            pick = int'($urandom_range(0, 99));
            if (cur_mode == MODE_GENERATE)
                n = int'($urandom_range(1, 12));
            else if (pick % 4 == 0)
                n = int'($urandom_range(1, want_len + 2));
            else
                n = int'(want_len);
            if (pick < 65)
                send_record(n, n, 1'($urandom_range(0, 1)), 40);
            else if (pick < 75)
                send_record(n, int'($urandom_range(0, n)), 1'b1, 40);
            else if (pick < 90)
            begin
                it = hdr(want_magic, want_version, $urandom, want_len, 1'b0);
                case ($urandom_range(0, 3))
                    0: it.read_fault = 1'b1;
                    1: it.stored_magic = it.stored_magic ^ $urandom;
                    2: it.stored_version = it.stored_version ^ $urandom;
                    default: it.stored_length = 16'($urandom);
                endcase
                send(it);
            end
            else if ($urandom_range(0, 1) == 0)
                send(dat(8'($urandom), 1'($urandom), 1'($urandom)));
            else
                send(hdr($urandom, $urandom, $urandom, 16'($urandom), 1'($urandom)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item_in = '0;
        cfg_we = 1'b0;
        cfg_index = REG_MODE;
        cfg_data = '0;
        cur_mode = MODE_VERIFY;
        want_magic = '0;
        want_version = '0;
        want_len = '0;
        hdr_sum = '0;
        rec_phase = AWAIT_HDR;
        restart_record();

        add_stim(hdr(32'h0, 32'h0, 32'h0, 16'h0, 1'b0), KNOWN, 1'b1, ST_OK, 32'h0);
        add_stim(hdr(32'h0, 32'h0, 32'hFFFFFFFF, 16'h0, 1'b0), KNOWN, 1'b1, ST_CRC, 32'h0);
        add_stim(hdr(32'h0, 32'h0, 32'h0, 16'h0, 1'b1), KNOWN, 1'b1, ST_READ, 32'h0);
        add_stim(hdr(32'hFFFFFFFF, 32'h0, 32'h0, 16'h0, 1'b0), KNOWN, 1'b1, ST_HEADER, 32'h0);
        add_stim(dat(8'hFF, 1'b1, 1'b0), KNOWN, 1'b0, ST_OK, 32'h0);
        add_write(REG_MAGIC, 32'hFFFFFFFF);
        add_write(REG_VERSION, 32'h0);
        add_write(REG_LENGTH, 32'd9);
        // check string "123456789"
        add_stim(hdr(32'hFFFFFFFF, 32'h0, 32'hCBF43926, 16'd9, 1'b0), KNOWN, 1'b0, ST_OK, 32'h0);
        for (int k = 1; k <= 9; k++)
            add_stim(dat(8'(8'h30 + k), k == 9, 1'b0), KNOWN, k == 9, ST_OK,
                     (k == 9) ? 32'hCBF43926 : 32'h0);
        add_stim(hdr(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 16'd9, 1'b0), KNOWN, 1'b1, ST_HEADER, 32'h0);
        add_stim(hdr(32'hFFFFFFFF, 32'h0, $urandom, 16'd9, 1'b0), CALC, 1'b0, ST_OK, 32'h0);
        add_stim(dat(8'($urandom), 1'b0, 1'b1), CALC, 1'b0, ST_OK, 32'h0);
        add_stim(dat(8'($urandom), 1'b1, 1'b0), CALC, 1'b0, ST_OK, 32'h0);
        // second header abandons the open record
        add_stim(hdr(32'hFFFFFFFF, 32'h0, $urandom, 16'd9, 1'b0), CALC, 1'b0, ST_OK, 32'h0);
        add_stim(hdr(32'hFFFFFFFF, 32'h0, $urandom, 16'd9, 1'b0), CALC, 1'b0, ST_OK, 32'h0);
        add_stim(dat(8'hFF, 1'b1, 1'b0), CALC, 1'b0, ST_OK, 32'h0);
        add_write(REG_MODE, {31'd0, MODE_GENERATE});
        add_stim(hdr($urandom, $urandom, $urandom, 16'($urandom), 1'b1), KNOWN, 1'b0, ST_OK,
                 32'h0);
        add_stim(dat(8'h00, 1'b1, 1'b0), KNOWN, 1'b1, ST_OK, 32'hD202EF8D);
        add_stim(dat(8'hFF, 1'b1, 1'b1), CALC, 1'b0, ST_OK, 32'h0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            case (plan[i].kind)
                ROW_WRITE:
                begin
                    settle();
                    write_reg(plan[i].idx, plan[i].val);
                end
                ROW_TYPED: send_item(plan[i].stim, 1'b1, plan[i].has_res, plan[i].res);
                default:   send(plan[i].stim);
            endcase
        end

        configure(MODE_VERIFY, $urandom, $urandom, 16'($urandom_range(1, 8)));
        run_records(250);

        // result side held off while headers keep coming
        configure(MODE_VERIFY, 32'h0, 32'h0, 16'd4);
        src_idle = 1'b0;
        hold_req <= 1'b1;
        for (int k = 0; k < 40; k++)
            send(hdr(32'hFFFFFFFF, $urandom, $urandom, 16'($urandom), 1'($urandom)));
        src_idle = 1'b1;

        configure(MODE_VERIFY, 32'h0, 32'hFFFFFFFF, 16'd1);
        run_records(200);
        configure(MODE_VERIFY, 32'hFFFFFFFF, 32'h0, 16'd0);
        run_records(150);
        configure(MODE_GENERATE, $urandom, $urandom, 16'($urandom));
        run_records(250);
        configure(MODE_VERIFY, $urandom, $urandom, 16'($urandom_range(2, 16)));
        run_records(250);

        configure(MODE_GENERATE, $urandom, $urandom, 16'($urandom));
        run_records(150);

        src_idle = 1'b0;
        sink_idle <= 1'b0;
        configure(MODE_VERIFY, $urandom, $urandom, 16'($urandom_range(1, 6)));
        run_records(300);

        settle();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== stored_record_crc_checker.f =====
sv/srcc_pkg.sv
sv/srcc_queue.sv
sv/srcc_front.sv
sv/srcc_back.sv
sv/stored_record_crc_checker.sv
test/stored_record_crc_checker_tb.sv
